FILE: rtl/vector_store_random_sampler_unit_defines.svh
// ----------------------------------------------------------------------------
// Vector store random sampler assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef VECTOR_STORE_RANDOM_SAMPLER_UNIT_DEFINES_SVH
`define VECTOR_STORE_RANDOM_SAMPLER_UNIT_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define VSRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every rising clock edge, reset included.
`define VSRS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/vsrs_pkg.sv
// ----------------------------------------------------------------------------
// Vector store random sampler package
// Widths, constants and shared types of the sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package vsrs_pkg;

    localparam int MAX_VECTORS = 256;
    localparam int MAX_DIM     = 16;

    localparam int POS_W   = $clog2(MAX_VECTORS);
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int MEM_AW  = POS_W + IDX_W;
    localparam int MEM_DEPTH = MAX_VECTORS * MAX_DIM;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 9;
    localparam int DIM_W   = 5;
    localparam int SEED_W  = 31;
    localparam int MULT_W  = 15;
    localparam int MUL_W   = SEED_W + MULT_W;
    localparam int SCALE_W = SEED_W + POS_W;

    localparam int IN_FIELDS_W  = POS_W + IDX_W + DATA_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = DATA_W + IDX_W + POS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_AW = 4;
    localparam int APB_W  = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SEED_W-1:0]  PM_MOD  = 31'h7FFF_FFFF;
    localparam logic [SEED_W-1:0]  PM_XOR  = 31'd123459876;
    localparam logic [MULT_W-1:0]  PM_MULT = 15'd16807;
    localparam logic [SCALE_W-1:0] PM_HALF = SCALE_W'(PM_MOD >> 1);

    localparam logic [COUNT_W-1:0] COUNT_RESET  = 9'd256;
    localparam logic [DIM_W-1:0]   DIM_RESET    = 5'd16;
    localparam logic [DATA_W-1:0]  THRESH_RESET = 32'd0;
    localparam logic [SEED_W-1:0]  SEED_RESET   = 31'd1;

    localparam logic [1:0] REG_COUNT  = 2'd0;
    localparam logic [1:0] REG_DIM    = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;
    localparam logic [1:0] REG_SEED   = 2'd3;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_RAND  = 2'd2,
        OP_SEEK  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RND_MUL,
        ST_RND_MOD,
        ST_RND_SCALE,
        ST_RND_ADD,
        ST_RND_POS,
        ST_SCAN,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [POS_W-1:0]  pos;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [POS_W-1:0]  cnt_m1;
        logic [IDX_W-1:0]  dim_m1;
        logic [DATA_W-1:0] threshold;
        logic [SEED_W-1:0] seed;
        logic              seed_ld;
    } t_cfg;

endpackage

`default_nettype wire

FILE: rtl/vsrs_cfg.sv
// ----------------------------------------------------------------------------
// Vector store random sampler register file
// APB-style register bank with range clamping of count and dimension.
// ----------------------------------------------------------------------------
`default_nettype none

module vsrs_cfg
    import vsrs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [APB_W-1:0]  pwdata,
    output logic      [APB_W-1:0]  prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [COUNT_W-1:0] r_count;
    logic [DIM_W-1:0]   r_dim;
    logic [DATA_W-1:0]  r_thresh;
    logic [SEED_W-1:0]  r_seed;
    logic               r_seed_ld;
    logic               wr_en;
    logic [1:0]         reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[CFG_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= COUNT_RESET;
            r_dim     <= DIM_RESET;
            r_thresh  <= THRESH_RESET;
            r_seed    <= SEED_RESET;
            r_seed_ld <= 1'b0;
        end else begin
            r_seed_ld <= 1'b0;
            if (wr_en) begin
                case (reg_sel)
                    REG_COUNT:  r_count  <= pwdata[COUNT_W-1:0];
                    REG_DIM:    r_dim    <= pwdata[DIM_W-1:0];
                    REG_THRESH: r_thresh <= pwdata[DATA_W-1:0];
                    REG_SEED: begin
                        r_seed    <= pwdata[SEED_W-1:0];
                        r_seed_ld <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (reg_sel)
            REG_COUNT:  prdata = APB_W'(r_count);
            REG_DIM:    prdata = APB_W'(r_dim);
            REG_THRESH: prdata = APB_W'(r_thresh);
            REG_SEED:   prdata = APB_W'(r_seed);
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        if (r_count == '0) begin
            o_cfg.cnt_m1 = '0;
        end else if (r_count > COUNT_W'(MAX_VECTORS)) begin
            o_cfg.cnt_m1 = POS_W'(MAX_VECTORS - 1);
        end else begin
            o_cfg.cnt_m1 = POS_W'(r_count - 1'b1);
        end
        if (r_dim == '0) begin
            o_cfg.dim_m1 = '0;
        end else if (r_dim > DIM_W'(MAX_DIM)) begin
            o_cfg.dim_m1 = IDX_W'(MAX_DIM - 1);
        end else begin
            o_cfg.dim_m1 = IDX_W'(r_dim - 1'b1);
        end
        o_cfg.threshold = r_thresh;
        o_cfg.seed      = r_seed;
        o_cfg.seed_ld   = r_seed_ld;
    end

endmodule

`default_nettype wire

FILE: rtl/vsrs_front.sv
// ----------------------------------------------------------------------------
// Vector store random sampler front end
// Accepts input beats, decodes the action and queues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module vsrs_front
    import vsrs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] i_s_axis_tdata,
    input  wire logic [1:0]            i_s_axis_tuser,
    output logic                       o_cmd_vld,
    input  wire logic                  i_cmd_rdy,
    output t_cmd                       o_cmd
);

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    t_cmd              n_cmd;
    logic              push;
    logic              pop;

    assign o_s_axis_tready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_cmd_vld       = (r_cnt != '0);
    assign o_cmd           = r_q[r_rd_ptr];
    assign push            = i_s_axis_tvalid & o_s_axis_tready;
    assign pop             = o_cmd_vld & i_cmd_rdy;

    always_comb begin
        case (i_s_axis_tuser)
            OP_WRITE: n_cmd.op = OP_WRITE;
            OP_READ:  n_cmd.op = OP_READ;
            OP_RAND:  n_cmd.op = OP_RAND;
            OP_SEEK:  n_cmd.op = OP_SEEK;
            default:  n_cmd.op = OP_READ;
        endcase
        n_cmd.pos   = i_s_axis_tdata[POS_W-1:0];
        n_cmd.idx   = i_s_axis_tdata[POS_W +: IDX_W];
        n_cmd.value = i_s_axis_tdata[POS_W+IDX_W +: DATA_W];
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/vsrs_back.sv
// ----------------------------------------------------------------------------
// Vector store random sampler back end
// Vector memory, random position generator, threshold scan and readout.
// ----------------------------------------------------------------------------
`default_nettype none

module vsrs_back
    import vsrs_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire logic                   i_cmd_vld,
    output logic                        o_cmd_rdy,
    input  wire t_cmd                   i_cmd,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic [0:0]                  o_m_axis_tuser,
    output logic                        o_m_axis_tlast
);

    logic [DATA_W-1:0]      r_mem [MEM_DEPTH];
    logic [DATA_W-1:0]      r_rd_data;

    t_state                 r_state;
    t_state                 n_state;
    logic [SEED_W-1:0]      r_gen;
    logic [MUL_W-1:0]       r_mul;
    logic [POS_W-1:0]       r_pos;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_issued;
    logic                   r_cmp_vld;
    logic                   r_cmp_last;
    logic                   r_found;
    logic                   r_seek;
    logic [COUNT_W-1:0]     r_tries;
    logic                   r_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_found;
    logic                   r_out_last;

    logic [SEED_W:0]        red_sum;
    logic [SEED_W-1:0]      red;
    logic [SEED_W:0]        rem_sum;
    logic [POS_W-1:0]       pos_calc;
    logic                   above;
    logic                   found_now;
    logic                   scan_done;
    logic                   retry;
    logic                   out_free;
    logic                   idx_last;

    logic                   cmd_take;
    logic                   mem_we;
    logic                   scan_start;
    logic                   seek_start;
    logic                   issue;
    logic                   emit_start;
    logic                   out_load;

    assign red_sum  = {1'b0, r_mul[SEED_W-1:0]} + (SEED_W+1)'(r_mul[MUL_W-1:SEED_W]);
    assign red      = (red_sum >= {1'b0, PM_MOD}) ? SEED_W'(red_sum - {1'b0, PM_MOD})
                                                  : SEED_W'(red_sum);
    assign rem_sum  = {1'b0, r_mul[SEED_W-1:0]} + (SEED_W+1)'(r_mul[SCALE_W-1:SEED_W]);
    assign pos_calc = r_mul[SCALE_W-1:SEED_W] + POS_W'(rem_sum >= {1'b0, PM_MOD});

    assign above     = $signed(r_rd_data) > $signed(i_cfg.threshold);
    assign found_now = r_found | above;
    assign scan_done = r_cmp_vld & r_cmp_last;
    assign retry     = r_seek & ~found_now & (r_tries <= COUNT_W'(i_cfg.cnt_m1));
    assign out_free  = ~r_out_vld | i_m_axis_tready;
    assign idx_last  = (r_idx == i_cfg.dim_m1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_vld) begin
                    case (i_cmd.op)
                        OP_WRITE: n_state = ST_IDLE;
                        OP_READ:  n_state = ST_SCAN;
                        default:  n_state = ST_RND_MUL;
                    endcase
                end
            end
            ST_RND_MUL:   n_state = ST_RND_MOD;
            ST_RND_MOD:   n_state = ST_RND_SCALE;
            ST_RND_SCALE: n_state = ST_RND_ADD;
            ST_RND_ADD:   n_state = ST_RND_POS;
            ST_RND_POS:   n_state = ST_SCAN;
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = retry ? ST_RND_MUL : ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:   n_state = ST_EMIT_LD;
            ST_EMIT_LD: begin
                if (out_free) begin
                    n_state = idx_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_rdy  = (r_state == ST_IDLE);
        cmd_take   = o_cmd_rdy & i_cmd_vld;
        mem_we     = cmd_take & (i_cmd.op == OP_WRITE);
        seek_start = cmd_take & ((i_cmd.op == OP_RAND) || (i_cmd.op == OP_SEEK));
        scan_start = (cmd_take & (i_cmd.op == OP_READ)) | (r_state == ST_RND_POS);
        issue      = (r_state == ST_SCAN) & ~r_issued;
        emit_start = (r_state == ST_SCAN) & scan_done & ~retry;
        out_load   = (r_state == ST_EMIT_LD) & out_free;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[{i_cmd.pos, i_cmd.idx}] <= i_cmd.value;
        end
        r_rd_data <= r_mem[{r_pos, r_idx}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_gen     <= SEED_RESET;
            r_tries   <= '0;
            r_issued  <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.seed_ld) begin
                r_gen <= i_cfg.seed;
            end else if (r_state == ST_RND_MOD) begin
                r_gen <= red ^ PM_XOR;
            end
            if (seek_start) begin
                r_tries <= '0;
            end else if (r_state == ST_RND_POS) begin
                r_tries <= r_tries + 1'b1;
            end
            if (scan_start) begin
                r_issued <= 1'b0;
            end else if (issue && idx_last) begin
                r_issued <= 1'b1;
            end
            r_cmp_vld <= issue;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_RND_MUL:   r_mul <= MUL_W'(r_gen ^ PM_XOR) * MUL_W'(PM_MULT);
            ST_RND_MOD:   r_mul <= MUL_W'(red);
            ST_RND_SCALE: r_mul <= MUL_W'(i_cfg.cnt_m1) * MUL_W'(r_mul[SEED_W-1:0]);
            ST_RND_ADD:   r_mul <= MUL_W'(r_mul[SCALE_W-1:0]) + MUL_W'(PM_HALF);
            default:      r_mul <= r_mul;
        endcase
        if (cmd_take) begin
            r_pos <= i_cmd.pos;
        end else if (r_state == ST_RND_POS) begin
            r_pos <= pos_calc;
        end
        if (cmd_take) begin
            r_seek <= (i_cmd.op == OP_SEEK);
        end
        if (scan_start || emit_start) begin
            r_idx <= '0;
        end else if ((issue || out_load) && !idx_last) begin
            r_idx <= r_idx + 1'b1;
        end
        r_cmp_last <= issue & idx_last;
        if (scan_start) begin
            r_found <= 1'b0;
        end else if ((r_state == ST_SCAN) && r_cmp_vld) begin
            r_found <= found_now;
        end
        if (out_load) begin
            r_out_data  <= OUT_TDATA_W'({r_pos, r_idx, r_rd_data});
            r_out_found <= r_found;
            r_out_last  <= idx_last;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_found;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/vector_store_random_sampler_unit.sv
// ----------------------------------------------------------------------------
// Vector store random sampler unit
// Use: a store of 256 vectors of 16 Q16.16 words with random vector draws.
// Input beats carry an action in tuser (0 write element, 1 read vector,
// 2 random read, 3 random read until an element exceeds the threshold).
// Reads return one beat per element, tlast on the final element and the
// threshold flag in tuser. The APB port sets count, dimension, threshold
// and generator seed; the user must make writes only while the unit is idle,
// as the block itself does not enforce this. A read scans the vector, then reads
// each element from memory into a beat; the back end takes no new command
// until then. A random draw passes the generator steps multiply, reduce, scale,
// add and position; a seeking read repeats draw and scan up to count times.
// A two-entry command queue accepts beats until full while output is stalled;
// a stalled output holds its beat and the readout waits.
// Synchronous reset clears the queue, output valid and generator state;
// the vector memory is not cleared, so read only words that were written.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_store_random_sampler_unit
    import vsrs_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // Fields from bit 0: position, element_index, value, zero padding.
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // Fields from bit 0: action.
    input  wire logic [1:0]             i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // Fields from bit 0: element_value, element_number, vector_position, zero padding.
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // Fields from bit 0: found (an element of the vector exceeds the threshold).
    output logic [0:0]                  o_m_axis_tuser,
    output logic                        o_m_axis_tlast,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_AW-1:0]      paddr,
    input  wire logic [APB_W-1:0]       pwdata,
    output logic      [APB_W-1:0]       prdata,
    output logic                        pready
);

    t_cfg cfg;
    t_cmd cmd;
    logic cmd_vld;
    logic cmd_rdy;

    vsrs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    vsrs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_cmd_vld       (cmd_vld),
        .i_cmd_rdy       (cmd_rdy),
        .o_cmd           (cmd)
    );

    vsrs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd_vld       (cmd_vld),
        .o_cmd_rdy       (cmd_rdy),
        .i_cmd           (cmd),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/vsrs_checker.sv
// ----------------------------------------------------------------------------
// Vector store random sampler checker
// Port-level checks on the output stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vector_store_random_sampler_unit_defines.svh"

module vsrs_checker
    import vsrs_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic [0:0]             o_m_axis_tuser,
    input wire logic                   o_m_axis_tlast
);

    logic                   stall;
    logic                   mid_beat;
    logic [POS_W+IDX_W-1:0] out_tag;
    logic [OUT_TDATA_W+1:0] out_word;
    logic [POS_W+IDX_W-1:0] r_tag_next;
    logic                   r_flag;
    logic                   order_ok;
    logic                   flag_ok;

    assign stall    = o_m_axis_tvalid & ~i_m_axis_tready;
    assign mid_beat = o_m_axis_tvalid & i_m_axis_tready & ~o_m_axis_tlast;
    assign out_tag  = o_m_axis_tdata[DATA_W +: POS_W+IDX_W];
    assign out_word = {o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast};
    assign order_ok = ~o_m_axis_tvalid | (out_tag == r_tag_next);
    assign flag_ok  = ~o_m_axis_tvalid | (o_m_axis_tuser[0] == r_flag);

    // The next beat of a vector keeps the position and steps the element number.
    always_ff @(posedge i_clk) begin
        if (mid_beat) begin
            r_tag_next <= out_tag + 1'b1;
            r_flag     <= o_m_axis_tuser[0];
        end
    end

    `VSRS_ASSERT(a_out_hold, stall |=> o_m_axis_tvalid && $stable(out_word), "Stalled beat changed")
    `VSRS_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_m_axis_tvalid, "Output valid after reset")
    `VSRS_ASSERT(a_elem_order, mid_beat |=> order_ok, "Element beats out of order within a vector")
    `VSRS_ASSERT(a_flag_const, mid_beat |=> flag_ok, "Threshold flag changed within a vector")

endmodule

bind vector_store_random_sampler_unit vsrs_checker u_vsrs_checker (.*);

`default_nettype wire

FILE: sim/tb_vector_store_random_sampler_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vector store random sampler unit testbench
// Drives element writes, plain reads, random reads and threshold seeks over
// the stream port, and moves the register settings through several phases
// over APB, the out-of-range counts and dimensions and the stuck generator
// seeds among them. A built-in predictor tracks the store, the generator
// and the settings, and checks every output beat in order. Random stalls
// are applied on both stream sides. Random draws are planned ahead, so a
// read never touches an element that was not written first.
// ----------------------------------------------------------------------------

module tb_vector_store_random_sampler_unit;
    import vsrs_pkg::*;

    localparam int STALL_LIMIT = 40000;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  number;
        logic [POS_W-1:0]  position;
        logic              found;
        logic              last;
    } t_elem;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [1:0]             s_tuser = OP_WRITE;
    logic                   m_tready = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CFG_AW-1:0]      paddr = '0;
    logic [APB_W-1:0]       pwdata = '0;

    wire                    s_tready;
    wire                    m_tvalid;
    wire [OUT_TDATA_W-1:0]  m_tdata;
    wire [0:0]              m_tuser;
    wire                    m_tlast;
    wire [APB_W-1:0]        prdata;
    wire                    pready;

    // Settings seen by both the planner and the predictor.
    logic [COUNT_W-1:0]     cfg_count = COUNT_RESET;
    logic [DIM_W-1:0]       cfg_dim = DIM_RESET;
    logic [DATA_W-1:0]      cfg_thresh = THRESH_RESET;

    // Image 0 is the planner's view of the store and generator, image 1 the
    // predictor's view, updated as beats are accepted.
    logic [SEED_W-1:0]      rng_img [2] = '{SEED_RESET, SEED_RESET};
    logic [DATA_W-1:0]      mem_img [2][MEM_DEPTH];
    logic [MAX_DIM-1:0]     plan_ok [MAX_VECTORS] = '{default: '0};

    t_cmd                   pending_cmds [$];
    t_elem                  due_elems [$];

    bit                     steady = 1'b0;
    bit                     s_took = 1'b0;
    int                     stall_cyc = 0;
    int                     n_bad = 0;
    int                     n_beats = 0;
    int                     n_ops [4] = '{default: 0};

    vector_store_random_sampler_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic int eff_count();
        if (cfg_count == 0) return 1;
        if (cfg_count > MAX_VECTORS) return MAX_VECTORS;
        return int'(cfg_count);
    endfunction

    function automatic int eff_dim();
        if (cfg_dim == 0) return 1;
        if (cfg_dim > MAX_DIM) return MAX_DIM;
        return int'(cfg_dim);
    endfunction

    function automatic logic [POS_W-1:0] next_pos(input int img);
        logic [63:0] x;
        logic [63:0] c;
        x = 64'(rng_img[img] ^ PM_XOR);
        x = (x * 64'(PM_MULT)) % 64'(PM_MOD);
        rng_img[img] = SEED_W'(x) ^ PM_XOR;
        c = 64'(eff_count() - 1);
        return POS_W'((2 * c * x + 64'(PM_MOD)) / (2 * 64'(PM_MOD)));
    endfunction

    function automatic bit row_hot(input int img, input int p);
        for (int i = 0; i < eff_dim(); i++)
            if ($signed(mem_img[img][p * MAX_DIM + i]) > $signed(cfg_thresh)) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit row_ready(input int p);
        logic [MAX_DIM:0] need;
        need = (17'd1 << eff_dim()) - 17'd1;
        return (plan_ok[p] & need[MAX_DIM-1:0]) == need[MAX_DIM-1:0];
    endfunction

    task automatic queue_vector(input int p);
        bit hot;
        int d;
        hot = row_hot(1, p);
        d = eff_dim();
        for (int i = 0; i < d; i++)
            due_elems.push_back('{mem_img[1][p * MAX_DIM + i], IDX_W'(i), POS_W'(p), hot,
                                  i == d - 1});
    endtask

    task automatic store_apply(input t_cmd c);
        logic [POS_W-1:0] p;
        int tries;
        n_ops[c.op]++;
        case (c.op)
            OP_WRITE: mem_img[1][{c.pos, c.idx}] = c.value;
            OP_READ:  queue_vector(c.pos);
            OP_RAND:  queue_vector(next_pos(1));
            OP_SEEK: begin
                tries = 0;
                do begin
                    p = next_pos(1);
                    tries++;
                end while (tries < eff_count() && !row_hot(1, p));
                queue_vector(p);
            end
        endcase
    endtask

    // Rows whose position is a multiple of four hold values at or below the
    // threshold, so that seeks have to retry.
    function automatic logic [DATA_W-1:0] pick_value(input logic [POS_W-1:0] p);
        if (p[1:0] == 2'b00) begin
            if ($signed(cfg_thresh) < $signed(32'h8000_0004)) return 32'h8000_0000;
            return cfg_thresh - 32'($urandom_range(3));
        end
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return cfg_thresh + 32'($urandom_range(2));
            default: return $urandom;
        endcase
    endfunction

    task automatic plan_write(input logic [POS_W-1:0] p, input logic [IDX_W-1:0] k,
                              input logic [DATA_W-1:0] v);
        mem_img[0][{p, k}] = v;
        plan_ok[p][k] = 1'b1;
        pending_cmds.push_back('{OP_WRITE, p, k, v});
    endtask

    task automatic fill_row(input logic [POS_W-1:0] p);
        int k;
        k = 0;
        while (plan_ok[p][k]) k++;
        plan_write(p, IDX_W'(k), pick_value(p));
    endtask

    // A read that would touch an unwritten element is replaced by a write
    // of the first missing element of that row.
    task automatic plan_read(input t_op op, input logic [POS_W-1:0] p);
        logic [SEED_W-1:0] saved;
        logic [POS_W-1:0] q;
        int tries;
        bit blocked;
        saved = rng_img[0];
        q = p;
        tries = 0;
        if (op == OP_READ) begin
            blocked = !row_ready(q);
        end else if (op == OP_RAND) begin
            q = next_pos(0);
            blocked = !row_ready(q);
        end else begin
            do begin
                q = next_pos(0);
                tries++;
                blocked = !row_ready(q);
            end while (!blocked && tries < eff_count() && !row_hot(0, q));
        end
        if (blocked) begin
            rng_img[0] = saved;
            fill_row(q);
        end else begin
            pending_cmds.push_back('{op, p, IDX_W'($urandom), DATA_W'($urandom)});
        end
    endtask

    task automatic plan_random();
        logic [POS_W-1:0] p;
        int r;
        r = $urandom_range(99);
        if (r < 35) begin
            p = ($urandom_range(3) == 0) ? POS_W'($urandom)
                                         : POS_W'($urandom_range(eff_count() - 1));
            plan_write(p, IDX_W'($urandom), pick_value(p));
        end else if (r < 60) begin
            plan_read(OP_READ, POS_W'($urandom_range(eff_count() - 1)));
        end else if (r < 80) begin
            plan_read(OP_RAND, POS_W'($urandom));
        end else begin
            plan_read(OP_SEEK, POS_W'($urandom));
        end
    endtask

    task automatic reg_write(input logic [1:0] r, input logic [APB_W-1:0] d);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {r, 2'b00};
        pwdata  <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_COUNT:  cfg_count = d[COUNT_W-1:0];
            REG_DIM:    cfg_dim = d[DIM_W-1:0];
            REG_THRESH: cfg_thresh = d[DATA_W-1:0];
            REG_SEED: begin
                rng_img[0] = d[SEED_W-1:0];
                rng_img[1] = d[SEED_W-1:0];
            end
        endcase
    endtask

    // Writes cause no beats, so a short margin lets the last ones retire.
    task automatic wait_idle();
        @(posedge i_clk);
        while (pending_cmds.size() != 0 || s_tvalid || due_elems.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [COUNT_W-1:0] cnt, input logic [DIM_W-1:0] dim,
                             input logic [DATA_W-1:0] thr, input logic [SEED_W-1:0] seed,
                             input int n, input bit calm);
        wait_idle();
        steady = calm;
        reg_write(REG_COUNT, APB_W'(cnt));
        reg_write(REG_DIM, APB_W'(dim));
        reg_write(REG_THRESH, thr);
        reg_write(REG_SEED, APB_W'(seed));
        repeat (n / 2) plan_random();
        wait_idle();
        repeat (n - n / 2) plan_random();
    endtask

    always @(negedge i_clk) begin : source
        t_cmd next_cmd;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (pending_cmds.size() != 0 && (steady || $urandom_range(99) >= 31)) begin
                next_cmd = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= IN_TDATA_W'({next_cmd.value, next_cmd.idx, next_cmd.pos});
                s_tuser  <= next_cmd.op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        m_tready <= steady || ($urandom_range(99) >= 31);
    end

    always @(posedge i_clk) begin : monitor
        t_cmd c;
        t_elem got;
        t_elem want;
        bit moved;
        moved = psel && penable && pwrite && pready;
        s_took = i_rst_n && s_tvalid && s_tready;
        if (s_took) begin
            c.op    = t_op'(s_tuser);
            c.pos   = s_tdata[POS_W-1:0];
            c.idx   = s_tdata[POS_W +: IDX_W];
            c.value = s_tdata[POS_W + IDX_W +: DATA_W];
            store_apply(c);
            moved = 1'b1;
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            moved = 1'b1;
            n_beats++;
            got = '{m_tdata[DATA_W-1:0], m_tdata[DATA_W +: IDX_W],
                    m_tdata[DATA_W + IDX_W +: POS_W], m_tuser[0], m_tlast};
            if (due_elems.size() == 0) begin
                n_bad++;
                if (n_bad <= MAX_SHOWN)
                    $display("%0t: beat with nothing pending: value %h number %0d pos %0d",
                             $realtime, got.value, got.number, got.position);
            end else begin
                want = due_elems.pop_front();
                if (got !== want) begin
                    n_bad++;
                    if (n_bad <= MAX_SHOWN)
                        $display({"%0t: expected/actual value %h/%h number %0d/%0d ",
                                  "pos %0d/%0d found %b/%b last %b/%b"}, $realtime,
                                 want.value, got.value, want.number, got.number,
                                 want.position, got.position, want.found, got.found,
                                 want.last, got.last);
                end
            end
        end
        stall_cyc = moved ? 0 : stall_cyc + 1;
    end

    initial begin
        @(posedge i_clk);
        while (stall_cyc < STALL_LIMIT) @(negedge i_clk);
        $display("Watchdog: no beat moved for %0d cycles.", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        reg_write(REG_COUNT, 32'd3);
        reg_write(REG_DIM, 32'd3);
        reg_write(REG_THRESH, 32'd0);
        reg_write(REG_SEED, 32'd5);
        plan_write(8'd0, 4'd0, 32'h7FFF_FFFF);
        plan_write(8'd0, 4'd1, 32'h8000_0000);
        plan_write(8'd0, 4'd2, 32'h0000_0000);
        plan_write(8'd1, 4'd0, 32'h0000_0000);
        plan_write(8'd1, 4'd1, 32'h0000_0000);
        plan_write(8'd1, 4'd2, 32'h8000_0000);
        plan_write(8'd2, 4'd0, 32'hFFFF_FFFF);
        plan_write(8'd2, 4'd1, 32'h8000_0001);
        plan_write(8'd2, 4'd2, 32'h0000_0000);
        plan_write(8'd255, 4'd0, 32'h0001_0000);
        plan_write(8'd255, 4'd1, 32'hFFFF_0000);
        plan_write(8'd255, 4'd2, 32'h0000_0001);
        plan_write(8'd255, 4'd15, 32'hA5A5_5A5A);
        plan_read(OP_READ, 8'd0);
        plan_read(OP_READ, 8'd1);
        plan_read(OP_READ, 8'd2);
        plan_read(OP_READ, 8'd255);
        repeat (2) plan_read(OP_RAND, POS_W'($urandom));
        repeat (3) plan_read(OP_SEEK, POS_W'($urandom));

        run_phase(9'd256, 5'd1, 32'h8000_0000, 31'd0, 40, 1'b0);
        run_phase(9'd1, 5'd16, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 30, 1'b0);
        run_phase(9'd0, 5'd0, $urandom, PM_XOR, 15, 1'b0);
        run_phase(9'd511, 5'd31, 32'd0, PM_MOD ^ PM_XOR, 15, 1'b0);
        run_phase(9'd8, 5'd4, 32'($urandom_range(32'h0002_0000)),
                  SEED_W'($urandom_range(32'h7FFF_FFFE)), 60, 1'b1);
        run_phase(9'd16, 5'd16, 32'h0000_8000,
                  SEED_W'($urandom_range(32'h7FFF_FFFE)), 60, 1'b0);
        run_phase(COUNT_W'($urandom_range(40, 2)), DIM_W'($urandom_range(16, 1)), $urandom,
                  SEED_W'($urandom_range(32'h7FFF_FFFE)), 40, 1'b0);

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (due_elems.size() != 0) begin
            $display("%0d result beats never arrived.", due_elems.size());
            n_bad += due_elems.size();
        end
        $display("Run covered %0d element writes, %0d vector reads, %0d random reads and %0d %s",
                 n_ops[OP_WRITE], n_ops[OP_READ], n_ops[OP_RAND], n_ops[OP_SEEK],
                 "threshold seeks.");
        $display("Checked %0d result beats over eight register settings; %0d failures.",
                 n_beats, n_bad);
        if (n_bad == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
